FILE: rtl/core/tbsm_pkg.sv
// ----------------------------------------------------------------------------
// tbsm_pkg
// Shared types and constants for the triple buffer slot manager.
// ----------------------------------------------------------------------------
package tbsm_pkg;

  // Slot index width is fixed by the out_slot field
  localparam int unsigned SLOT_W        = 2;
  localparam int unsigned NUM_SLOTS_DEF = 3;

  localparam logic [SLOT_W-1:0] NO_SLOT   = 2'd3;
  localparam logic signed [7:0] NO_SOURCE = -8'sd1;
  localparam logic [31:0]       SEQ_RESET = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_QUERY   = 2'd1,
    OP_ACQUIRE = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BUSY    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_INVALID = 3'd3,
    ST_STALE   = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [63:0]        in_timestamp;
    logic [31:0]        in_sequence;
    logic               in_valid;
    logic [31:0]        in_payload_handle;
    logic signed [7:0]  in_source_id;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [1:0]         out_slot;
    logic [63:0]        out_timestamp;
    logic [31:0]        out_sequence;
    logic [31:0]        out_payload_handle;
    logic signed [7:0]  out_source_id;
  } out_item_t;

  // One slot entry in the metadata memory
  typedef struct packed {
    logic [63:0]        timestamp;
    logic [31:0]        sequence_num;
    logic               valid;
    logic [31:0]        payload;
    logic signed [7:0]  source;
  } entry_t;

  // Memory port controls from the sequencer
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } mem_req_t;

endpackage

FILE: rtl/core/tbsm_if.sv
// ----------------------------------------------------------------------------
// tbsm_in_if / tbsm_out_if
// Valid/ready channels carrying operation requests and results.
// ----------------------------------------------------------------------------
interface tbsm_in_if;
  logic               valid;
  logic               ready;
  tbsm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tbsm_out_if;
  logic                valid;
  logic                ready;
  tbsm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/tbsm_slot_mem.sv
// ----------------------------------------------------------------------------
// tbsm_slot_mem
// Slot metadata memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tbsm_slot_mem #(
  parameter int unsigned NUM_SLOTS = tbsm_pkg::NUM_SLOTS_DEF
) (
  input  logic               clk_i,
  input  tbsm_pkg::mem_req_t req_i,
  output tbsm_pkg::entry_t   rd_data_o
);
  import tbsm_pkg::*;

  entry_t mem_q [NUM_SLOTS];
  entry_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Read port, registered data, data holds between reads
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/triple_buffer_slot_manager.sv
// ----------------------------------------------------------------------------
// triple_buffer_slot_manager
// Three-slot frame buffer manager: write, query, acquire and release.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation per transaction (write, query, acquire,
//   release) with the frame metadata used by write. out_o returns exactly
//   one result transaction per request, in request order.
//   For each request, the accept cycle issues the slot memory read (for a
//   write, the memory write and pointer update instead); S_EXEC then
//   evaluates the result from the registered read data and loads the
//   output register. A new request is not taken until the previous one
//   has loaded its result into the output register.
//   The output register decouples the channels: a request can be accepted
//   while a finished result waits; if that result is still not taken when
//   the next one is ready, the sequencer holds and in_i.ready stays low.
//   Reset: write slot 0, nothing published, no claim, last claimed sequence
//   all ones. Slot contents are undefined until written; only written slots
//   are ever published, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module triple_buffer_slot_manager #(
  parameter int unsigned NUM_SLOTS = tbsm_pkg::NUM_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbsm_in_if.sink    in_i,
  tbsm_out_if.source out_o
);
  import tbsm_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  state_e            state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] write_slot_q, write_slot_d;
  logic [SLOT_W-1:0] ready_slot_q, ready_slot_d;
  logic [SLOT_W-1:0] held_slot_q, held_slot_d;
  logic [31:0]       last_seq_q, last_seq_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  mem_req_t          mem_req;
  entry_t            rd_entry;

  logic              accept;
  logic              out_free;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] next_write;
  logic              found;
  logic [31:0]       seq_diff;
  logic              ready_ok;

  tbsm_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_entry)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign ready_ok   = (ready_slot_q <= LAST_SLOT);

  // Current write slot, falling back to slot 0 if out of range
  assign wr_slot = (write_slot_q <= LAST_SLOT) ? write_slot_q : '0;

  // Lowest slot that is neither just written nor held
  always_comb begin
    next_write = write_slot_q;
    found      = 1'b0;
    for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
      if (!found && SLOT_W'(i) != wr_slot && SLOT_W'(i) != held_slot_q) begin
        next_write = SLOT_W'(i);
        found      = 1'b1;
      end
    end
  end

  // Memory port requests
  always_comb begin
    mem_req                      = '0;
    mem_req.wr_addr              = wr_slot;
    mem_req.wr_data.timestamp    = in_i.data.in_timestamp;
    mem_req.wr_data.sequence_num = in_i.data.in_sequence;
    mem_req.wr_data.valid        = in_i.data.in_valid;
    mem_req.wr_data.payload      = in_i.data.in_payload_handle;
    mem_req.wr_data.source       = in_i.data.in_source_id;
    mem_req.rd_addr              = ready_slot_q;
    mem_req.wr_en = accept && (op_e'(in_i.data.operation) == OP_WRITE);
    mem_req.rd_en = accept && (op_e'(in_i.data.operation) != OP_WRITE) && ready_ok;
  end

  assign seq_diff = rd_entry.sequence_num - last_seq_q;

  // Sequencer: next state, pointer updates and result formation
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    slot_d       = slot_q;
    write_slot_d = write_slot_q;
    ready_slot_d = ready_slot_q;
    held_slot_d  = held_slot_q;
    last_seq_d   = last_seq_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_data_d   = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = in_i.data.operation;
          slot_d  = wr_slot;
          state_d = S_EXEC;
          if (op_e'(in_i.data.operation) == OP_WRITE) begin
            ready_slot_d = wr_slot;
            write_slot_d = next_write;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_d                   = 1'b1;
          state_d                       = S_IDLE;
          out_data_d.status             = ST_OK;
          out_data_d.out_slot           = NO_SLOT;
          out_data_d.out_timestamp      = '0;
          out_data_d.out_sequence       = '0;
          out_data_d.out_payload_handle = '0;
          out_data_d.out_source_id      = NO_SOURCE;
          case (op_e'(op_q))
            OP_WRITE: begin
              out_data_d.out_slot = slot_q;
            end
            OP_QUERY: begin
              if (!ready_ok) begin
                out_data_d.status = ST_EMPTY;
              end else begin
                out_data_d.status        = rd_entry.valid ? ST_OK : ST_INVALID;
                out_data_d.out_slot      = ready_slot_q;
                out_data_d.out_timestamp = rd_entry.timestamp;
                out_data_d.out_sequence  = rd_entry.sequence_num;
              end
            end
            OP_ACQUIRE: begin
              if (held_slot_q != NO_SLOT) begin
                out_data_d.status = ST_BUSY;
              end else if (!ready_ok) begin
                out_data_d.status = ST_EMPTY;
              end else if (!rd_entry.valid || rd_entry.payload == '0) begin
                out_data_d.status = ST_INVALID;
              end else if (seq_diff == '0 || seq_diff[31]) begin
                out_data_d.status = ST_STALE;
              end else begin
                held_slot_d                   = ready_slot_q;
                last_seq_d                    = rd_entry.sequence_num;
                out_data_d.out_slot           = ready_slot_q;
                out_data_d.out_timestamp      = rd_entry.timestamp;
                out_data_d.out_sequence       = rd_entry.sequence_num;
                out_data_d.out_payload_handle = rd_entry.payload;
                out_data_d.out_source_id      = rd_entry.source;
              end
            end
            OP_RELEASE: begin
              held_slot_d = NO_SLOT;
            end
            default: begin
              held_slot_d = held_slot_q;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      write_slot_q <= '0;
      ready_slot_q <= NO_SLOT;
      held_slot_q  <= NO_SLOT;
      last_seq_q   <= SEQ_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      write_slot_q <= write_slot_d;
      ready_slot_q <= ready_slot_d;
      held_slot_q  <= held_slot_d;
      last_seq_q   <= last_seq_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    slot_q     <= slot_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // A held slot is never the slot being written
  a_held_not_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_slot_q != NO_SLOT) |-> (held_slot_q != write_slot_q))
    else $error("held slot equals write slot");

  // A published slot is never the slot being written
  a_ready_not_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_slot_q != NO_SLOT) |-> (ready_slot_q != write_slot_q))
    else $error("ready slot equals write slot");

  // A granted claim always names the published slot
  a_grant_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && out_free && op_e'(op_q) == OP_ACQUIRE
     && held_slot_q == NO_SLOT && held_slot_d != NO_SLOT)
    |=> (held_slot_q == ready_slot_q && out_o.data.out_slot == ready_slot_q))
    else $error("claim does not match published slot");

endmodule
